### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising edge of clk, disabled while reset is low.
`define SLX_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication form: when the trigger holds, the consequence holds in the same cycle.
`define SLX_ASSERT_IMP(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/slx_pkg.sv
// ----------------------------------------------------------------------------
// Lexer package
// Types, token codes, character classes and the keyword table of the lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slx_pkg;

	localparam int MAX_NAMES    = 64;
	localparam int MAX_NAME_LEN = 16;
	localparam int NLEN_W       = $clog2(MAX_NAME_LEN + 2);
	localparam int BIDX_W       = $clog2(MAX_NAME_LEN);
	localparam int IDX_W        = $clog2(MAX_NAMES);
	localparam int CNT_W        = $clog2(MAX_NAMES + 1);
	localparam int NBUF_W       = 8 * MAX_NAME_LEN;
	localparam int KW_COUNT     = 19;

	localparam logic [5:0] K_END    = 6'd20;
	localparam logic [5:0] K_NUM    = 6'd40;
	localparam logic [5:0] K_STREND = 6'd41;
	localparam logic [5:0] K_NAME   = 6'd42;
	localparam logic [5:0] K_STRCH  = 6'd43;
	localparam logic [5:0] K_ERR    = 6'd44;

	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_BAD   = 3'd1;
	localparam logic [2:0] E_BANG  = 3'd2;
	localparam logic [2:0] E_OPEN  = 3'd3;
	localparam logic [2:0] E_FULL  = 3'd4;
	localparam logic [2:0] E_LONG  = 3'd5;
	localparam logic [2:0] E_OVER  = 3'd6;

	localparam logic [4:0] D_NONE   = 5'd0;
	localparam logic [4:0] D_STAR   = 5'd1;
	localparam logic [4:0] D_SLASH  = 5'd2;
	localparam logic [4:0] D_PLUS   = 5'd3;
	localparam logic [4:0] D_MINUS  = 5'd4;
	localparam logic [4:0] D_EQ     = 5'd5;
	localparam logic [4:0] D_LT     = 5'd6;
	localparam logic [4:0] D_GT     = 5'd7;
	localparam logic [4:0] D_LE     = 5'd8;
	localparam logic [4:0] D_GE     = 5'd9;
	localparam logic [4:0] D_EQEQ   = 5'd10;
	localparam logic [4:0] D_NE     = 5'd11;
	localparam logic [4:0] D_SEMI   = 5'd12;
	localparam logic [4:0] D_COLON  = 5'd13;
	localparam logic [4:0] D_COMMA  = 5'd14;
	localparam logic [4:0] D_DOT    = 5'd15;
	localparam logic [4:0] D_LPAR   = 5'd16;
	localparam logic [4:0] D_RPAR   = 5'd17;
	localparam logic [4:0] D_LBRACE = 5'd18;
	localparam logic [4:0] D_RBRACE = 5'd19;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_input;
	} in_t;

	typedef struct packed {
		logic [5:0]  token_kind;
		logic [30:0] token_value;
		logic [2:0]  error_code;
		logic        last;
	} tok_t;

	typedef enum logic [3:0] {
		M_START, M_NAME, M_NUMBER, M_CMP, M_BANG, M_SLASH, M_COMMENT, M_STAR, M_STRING
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE, S_DISP, S_KW, S_ID_WAIT, S_ID_CMP, S_ADD, S_SECOND
	} st_t;

	function automatic logic is_blank(logic [7:0] c);
		return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic [4:0] single_delim(logic [7:0] c);
		logic [4:0] d;
		unique case (c)
			8'h2A:   d = D_STAR;
			8'h2B:   d = D_PLUS;
			8'h2D:   d = D_MINUS;
			8'h3B:   d = D_SEMI;
			8'h3A:   d = D_COLON;
			8'h2C:   d = D_COMMA;
			8'h2E:   d = D_DOT;
			8'h28:   d = D_LPAR;
			8'h29:   d = D_RPAR;
			8'h7B:   d = D_LBRACE;
			8'h7D:   d = D_RBRACE;
			default: d = D_NONE;
		endcase
		return d;
	endfunction

	// True when the start state gives a result for this byte.
	function automatic logic start_emits(logic [7:0] c);
		return !(is_blank(c) || is_alpha(c) || is_digit(c) || c == CH_SLASH ||
			c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG || c == CH_QUOTE);
	endfunction

	function automatic tok_t mk_tok(logic [5:0] kind, logic [30:0] val, logic [2:0] err,
		logic lst);
		tok_t t;
		t.token_kind  = kind;
		t.token_value = val;
		t.error_code  = err;
		t.last        = lst;
		return t;
	endfunction

	// Compares the first len bytes of two name words; byte 0 sits in the low bits.
	function automatic logic name_eq(logic [NBUF_W-1:0] a, logic [NBUF_W-1:0] b,
		logic [NLEN_W-1:0] len);
		logic eq;
		eq = 1'b1;
		for (int i = 0; i < MAX_NAME_LEN; i++) begin
			if (i < int'(len) && a[8*i +: 8] != b[8*i +: 8]) begin
				eq = 1'b0;
			end
		end
		return eq;
	endfunction

	// Keyword text is right justified: the first letter is the highest byte in use.
	function automatic logic kw_match(logic [NBUF_W-1:0] name, logic [NLEN_W-1:0] len,
		logic [4:0] k);
		logic [63:0] txt;
		int          kl;
		logic        eq;
		unique case (k)
			5'd1:    begin txt = 64'("not");     kl = 3; end
			5'd2:    begin txt = 64'("and");     kl = 3; end
			5'd3:    begin txt = 64'("or");      kl = 2; end
			5'd4:    begin txt = 64'("if");      kl = 2; end
			5'd5:    begin txt = 64'("else");    kl = 4; end
			5'd6:    begin txt = 64'("for");     kl = 3; end
			5'd7:    begin txt = 64'("do");      kl = 2; end
			5'd8:    begin txt = 64'("while");   kl = 5; end
			5'd9:    begin txt = 64'("break");   kl = 5; end
			5'd10:   begin txt = 64'("goto");    kl = 4; end
			5'd11:   begin txt = 64'("read");    kl = 4; end
			5'd12:   begin txt = 64'("write");   kl = 5; end
			5'd13:   begin txt = 64'("true");    kl = 4; end
			5'd14:   begin txt = 64'("false");   kl = 5; end
			5'd15:   begin txt = 64'("int");     kl = 3; end
			5'd16:   begin txt = 64'("string");  kl = 6; end
			5'd17:   begin txt = 64'("bool");    kl = 4; end
			5'd18:   begin txt = 64'("struct");  kl = 6; end
			5'd19:   begin txt = 64'("program"); kl = 7; end
			default: begin txt = 64'd0;          kl = 0; end
		endcase
		eq = (kl != 0) && (int'(len) == kl);
		for (int i = 0; i < 8; i++) begin
			if (i < kl) begin
				if (name[8*i +: 8] != txt[8*(kl-1-i) +: 8]) begin
					eq = 1'b0;
				end
			end
		end
		return eq;
	endfunction

endpackage

### rtl/core/source_lexer_with_name_table.sv
// ----------------------------------------------------------------------------
// Source lexer with name table
// Scans source bytes into tokens and keeps a table of the names it has seen.
// ----------------------------------------------------------------------------
// One byte is taken per input transfer and gives up to two tokens, which leave
// one per output transfer; the last token of a byte has last set. Each byte is
// accepted, then dispatched, and a byte that ends a token may then be scanned
// again from the start state. When a name of at most 16 bytes ends, a small
// sequencer walks the 19 keywords with one compare a cycle, then the stored names
// through the registered read port of the table memory (a wait state, then a
// compare state for each), stopping at a match, then adds the name if it was not
// found and the table has room. A full output register that is not being drained
// holds back every step that has a token due. The table holds no entry after
// reset, so it needs no clearing pass. Input ready is low while a byte is being
// worked on.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module source_lexer_with_name_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  slx_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output slx_pkg::tok_t out_item
);
	import slx_pkg::*;

	localparam int ENT_W = NLEN_W + NBUF_W;

	// Sequencer and scanner state.
	st_t               st_q, nx_st;
	mode_t             mode_q, nx_mode;
	logic [7:0]        char_q, nx_char;
	logic              eoi_q, nx_eoi;
	logic [NBUF_W-1:0] nbuf_q;
	logic [NLEN_W-1:0] nlen_q, nx_nlen;
	logic [30:0]       acc_q, nx_acc;
	logic              over_q, nx_over;
	logic [7:0]        opf_q, nx_opf;
	logic [CNT_W-1:0]  cnt_q, nx_cnt;
	logic [4:0]        kw_q, nx_kw;
	logic [CNT_W-1:0]  idx_q, nx_idx;

	// Output register.
	logic              out_valid_q;
	tok_t              out_q;

	// Name table memory, one entry is the stored length above the name bytes.
	logic [ENT_W-1:0]  mem [MAX_NAMES];
	logic [ENT_W-1:0]  mem_rd_q;
	logic              mem_we;

	logic              nbuf_we;
	logic [BIDX_W-1:0] nbuf_widx;

	logic              emit_en;
	tok_t              e_item;
	logic              slot_free;
	logic              sec_emits;
	logic              alnum;
	logic [3:0]        digit;
	logic [34:0]       acc_x10;
	logic [4:0]        cmp_j;
	logic [4:0]        cmp2_j;
	logic [4:0]        sdel;

	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// The output register may take a new token when it is empty or being drained.
	assign slot_free = !out_valid_q || out_ready;
	// Whether the second pass over this byte gives a token decides the last flag.
	assign sec_emits = eoi_q || start_emits(char_q);
	assign alnum     = is_alpha(char_q) || is_digit(char_q);
	assign digit     = 4'(char_q - CH_ZERO);
	// Times ten as two shifted copies, plus the new digit.
	assign acc_x10   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 35'(digit);
	assign cmp_j     = (opf_q == CH_LT) ? D_LT : (opf_q == CH_GT) ? D_GT : D_EQ;
	assign cmp2_j    = (opf_q == CH_LT) ? D_LE : (opf_q == CH_GT) ? D_GE : D_EQEQ;
	assign sdel      = single_delim(char_q);

	always_comb begin
		nx_st     = st_q;
		nx_mode   = mode_q;
		nx_char   = char_q;
		nx_eoi    = eoi_q;
		nx_nlen   = nlen_q;
		nx_acc    = acc_q;
		nx_over   = over_q;
		nx_opf    = opf_q;
		nx_cnt    = cnt_q;
		nx_kw     = kw_q;
		nx_idx    = idx_q;
		emit_en   = 1'b0;
		e_item    = mk_tok(6'd0, 31'd0, E_NONE, 1'b1);
		mem_we    = 1'b0;
		nbuf_we   = 1'b0;
		nbuf_widx = nlen_q[BIDX_W-1:0];

		unique case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					nx_char = in_item.character;
					nx_eoi  = in_item.end_of_input;
					nx_st   = S_DISP;
				end
			end

			// First pass: the byte in the light of the pending token.
			S_DISP: begin
				if (eoi_q) begin
					unique case (mode_q)
						M_NAME: begin
							if (nlen_q > NLEN_W'(MAX_NAME_LEN)) begin
								if (slot_free) begin
									emit_en = 1'b1;
									e_item  = mk_tok(K_ERR, 31'd0, E_LONG, 1'b0);
									nx_nlen = '0;
									nx_st   = S_SECOND;
								end
							end else begin
								nx_kw = 5'd1;
								nx_st = S_KW;
							end
						end
						M_NUMBER: begin
							if (slot_free) begin
								emit_en = 1'b1;
								e_item  = over_q ? mk_tok(K_ERR, 31'd0, E_OVER, 1'b0)
								                 : mk_tok(K_NUM, acc_q, E_NONE, 1'b0);
								nx_st   = S_SECOND;
							end
						end
						M_SLASH: begin
							if (slot_free) begin
								emit_en = 1'b1;
								e_item  = mk_tok(6'(K_END + D_SLASH), 31'(D_SLASH), E_NONE, 1'b0);
								nx_st   = S_SECOND;
							end
						end
						M_CMP: begin
							if (slot_free) begin
								emit_en = 1'b1;
								e_item  = mk_tok(6'(K_END + cmp_j), 31'(cmp_j), E_NONE, 1'b0);
								nx_st   = S_SECOND;
							end
						end
						M_BANG: begin
							if (slot_free) begin
								emit_en = 1'b1;
								e_item  = mk_tok(K_ERR, 31'(CH_BANG), E_BANG, 1'b0);
								nx_st   = S_SECOND;
							end
						end
						M_COMMENT, M_STAR, M_STRING: begin
							if (slot_free) begin
								emit_en = 1'b1;
								e_item  = mk_tok(K_ERR, 31'd0, E_OPEN, 1'b1);
								nx_mode = M_START;
								nx_nlen = '0;
								nx_acc  = '0;
								nx_over = 1'b0;
								nx_st   = S_IDLE;
							end
						end
						default: nx_st = S_SECOND;
					endcase
				end else begin
					unique case (mode_q)
						M_NAME: begin
							if (alnum) begin
								if (nlen_q < NLEN_W'(MAX_NAME_LEN)) begin
									nbuf_we = 1'b1;
								end
								if (nlen_q <= NLEN_W'(MAX_NAME_LEN)) begin
									nx_nlen = nlen_q + 1'b1;
								end
								nx_st = S_IDLE;
							end else if (nlen_q > NLEN_W'(MAX_NAME_LEN)) begin
								if (slot_free) begin
									emit_en = 1'b1;
									e_item  = mk_tok(K_ERR, 31'd0, E_LONG, !sec_emits);
									nx_nlen = '0;
									nx_st   = S_SECOND;
								end
							end else begin
								nx_kw = 5'd1;
								nx_st = S_KW;
							end
						end
						M_NUMBER: begin
							if (is_digit(char_q)) begin
								if (acc_x10 > 35'h7FFF_FFFF) begin
									nx_over = 1'b1;
									nx_acc  = '1;
								end else begin
									nx_acc  = acc_x10[30:0];
								end
								nx_st = S_IDLE;
							end else if (slot_free) begin
								emit_en = 1'b1;
								e_item  = over_q ? mk_tok(K_ERR, 31'd0, E_OVER, !sec_emits)
								                 : mk_tok(K_NUM, acc_q, E_NONE, !sec_emits);
								nx_acc  = '0;
								nx_over = 1'b0;
								nx_st   = S_SECOND;
							end
						end
						M_SLASH: begin
							if (char_q == CH_STAR) begin
								nx_mode = M_COMMENT;
								nx_st   = S_IDLE;
							end else if (slot_free) begin
								emit_en = 1'b1;
								e_item  = mk_tok(6'(K_END + D_SLASH), 31'(D_SLASH), E_NONE,
									!sec_emits);
								nx_st   = S_SECOND;
							end
						end
						M_COMMENT: begin
							if (char_q == CH_STAR) begin
								nx_mode = M_STAR;
							end
							nx_st = S_IDLE;
						end
						M_STAR: begin
							if (char_q == CH_SLASH) begin
								nx_mode = M_START;
							end else if (char_q != CH_STAR) begin
								nx_mode = M_COMMENT;
							end
							nx_st = S_IDLE;
						end
						M_CMP: begin
							if (slot_free) begin
								emit_en = 1'b1;
								if (char_q == CH_EQ) begin
									e_item  = mk_tok(6'(K_END + cmp2_j), 31'(cmp2_j), E_NONE, 1'b1);
									nx_mode = M_START;
									nx_st   = S_IDLE;
								end else begin
									e_item  = mk_tok(6'(K_END + cmp_j), 31'(cmp_j), E_NONE,
										!sec_emits);
									nx_st   = S_SECOND;
								end
							end
						end
						M_BANG: begin
							if (slot_free) begin
								emit_en = 1'b1;
								if (char_q == CH_EQ) begin
									e_item  = mk_tok(6'(K_END + D_NE), 31'(D_NE), E_NONE, 1'b1);
									nx_mode = M_START;
									nx_st   = S_IDLE;
								end else begin
									e_item  = mk_tok(K_ERR, 31'(CH_BANG), E_BANG, !sec_emits);
									nx_st   = S_SECOND;
								end
							end
						end
						M_STRING: begin
							if (slot_free) begin
								emit_en = 1'b1;
								if (char_q == CH_QUOTE) begin
									e_item  = mk_tok(K_STREND, 31'd0, E_NONE, 1'b1);
									nx_mode = M_START;
								end else begin
									e_item  = mk_tok(K_STRCH, 31'(char_q), E_NONE, 1'b1);
								end
								nx_st = S_IDLE;
							end
						end
						default: nx_st = S_SECOND;
					endcase
				end
			end

			// Keyword walk, one word a cycle.
			S_KW: begin
				if (kw_match(nbuf_q, nlen_q, kw_q)) begin
					if (slot_free) begin
						emit_en = 1'b1;
						e_item  = mk_tok(6'(kw_q), 31'(kw_q), E_NONE, !sec_emits);
						nx_nlen = '0;
						nx_st   = S_SECOND;
					end
				end else if (kw_q == 5'(KW_COUNT)) begin
					nx_idx = '0;
					nx_st  = S_ID_WAIT;
				end else begin
					nx_kw = kw_q + 5'd1;
				end
			end

			// The table read for idx_q lands in mem_rd_q at the end of this cycle.
			S_ID_WAIT: begin
				nx_st = (idx_q >= cnt_q) ? S_ADD : S_ID_CMP;
			end

			S_ID_CMP: begin
				if (mem_rd_q[ENT_W-1 -: NLEN_W] == nlen_q &&
					name_eq(mem_rd_q[NBUF_W-1:0], nbuf_q, nlen_q)) begin
					if (slot_free) begin
						emit_en = 1'b1;
						e_item  = mk_tok(K_NAME, 31'(idx_q), E_NONE, !sec_emits);
						nx_nlen = '0;
						nx_st   = S_SECOND;
					end
				end else begin
					nx_idx = idx_q + 1'b1;
					nx_st  = S_ID_WAIT;
				end
			end

			S_ADD: begin
				if (slot_free) begin
					emit_en = 1'b1;
					if (cnt_q >= CNT_W'(MAX_NAMES)) begin
						e_item = mk_tok(K_ERR, 31'd0, E_FULL, !sec_emits);
					end else begin
						mem_we = 1'b1;
						e_item = mk_tok(K_NAME, 31'(cnt_q), E_NONE, !sec_emits);
						nx_cnt = cnt_q + 1'b1;
					end
					nx_nlen = '0;
					nx_st   = S_SECOND;
				end
			end

			// Second pass: the end token, or the byte again from the start state.
			S_SECOND: begin
				if (eoi_q) begin
					if (slot_free) begin
						emit_en = 1'b1;
						e_item  = mk_tok(K_END, 31'd0, E_NONE, 1'b1);
						nx_mode = M_START;
						nx_nlen = '0;
						nx_acc  = '0;
						nx_over = 1'b0;
						nx_st   = S_IDLE;
					end
				end else begin
					priority if (is_blank(char_q)) begin
						nx_mode = M_START;
						nx_st   = S_IDLE;
					end else if (is_alpha(char_q)) begin
						nbuf_we   = 1'b1;
						nbuf_widx = '0;
						nx_nlen   = NLEN_W'(1);
						nx_mode   = M_NAME;
						nx_st     = S_IDLE;
					end else if (is_digit(char_q)) begin
						nx_acc  = 31'(digit);
						nx_over = 1'b0;
						nx_mode = M_NUMBER;
						nx_st   = S_IDLE;
					end else if (char_q == CH_SLASH) begin
						nx_mode = M_SLASH;
						nx_st   = S_IDLE;
					end else if (char_q == CH_EQ || char_q == CH_LT || char_q == CH_GT) begin
						nx_opf  = char_q;
						nx_mode = M_CMP;
						nx_st   = S_IDLE;
					end else if (char_q == CH_BANG) begin
						nx_mode = M_BANG;
						nx_st   = S_IDLE;
					end else if (char_q == CH_QUOTE) begin
						nx_mode = M_STRING;
						nx_st   = S_IDLE;
					end else begin
						if (slot_free) begin
							emit_en = 1'b1;
							e_item  = (sdel != D_NONE)
								? mk_tok(6'(K_END + sdel), 31'(sdel), E_NONE, 1'b1)
								: mk_tok(K_ERR, 31'(char_q), E_BAD, 1'b1);
							nx_mode = M_START;
							nx_st   = S_IDLE;
						end
					end
				end
			end

			default: nx_st = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			mode_q      <= M_START;
			nlen_q      <= '0;
			acc_q       <= '0;
			over_q      <= 1'b0;
			opf_q       <= '0;
			cnt_q       <= '0;
			kw_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q   <= nx_st;
			mode_q <= nx_mode;
			nlen_q <= nx_nlen;
			acc_q  <= nx_acc;
			over_q <= nx_over;
			opf_q  <= nx_opf;
			cnt_q  <= nx_cnt;
			kw_q   <= nx_kw;
			idx_q  <= nx_idx;
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and the name buffer carry no reset.
	always_ff @(posedge clk) begin
		char_q <= nx_char;
		eoi_q  <= nx_eoi;
		if (emit_en) begin
			out_q <= e_item;
		end
		if (nbuf_we) begin
			nbuf_q[8*nbuf_widx +: 8] <= char_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cnt_q[IDX_W-1:0]] <= {nlen_q, nbuf_q};
		end
		mem_rd_q <= mem[idx_q[IDX_W-1:0]];
	end

	`SLX_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(MAX_NAMES), "name count beyond table size")
	`SLX_ASSERT(a_nlen_bound, nlen_q <= NLEN_W'(MAX_NAME_LEN + 1), "name length out of range")
	`SLX_ASSERT_IMP(a_cmp_in_table, st_q == S_ID_CMP, idx_q < cnt_q,
		"table compare past the stored names")
	`SLX_ASSERT_IMP(a_err_code, out_valid && out_item.token_kind == K_ERR,
		out_item.error_code != E_NONE, "error token without an error code")
	`SLX_ASSERT_IMP(a_no_code, out_valid && out_item.token_kind != K_ERR,
		out_item.error_code == E_NONE, "error code on a plain token")

endmodule
